[rtl/adnp_pkg.sv]
`timescale 1ns / 1ps

package adnp_pkg;

    localparam int CH_W            = 8;
    localparam int INT_W           = 32;
    localparam int FRAC_W          = 30;
    localparam int FRAC_CNT_W      = 4;
    localparam int DIGIT_W         = 4;
    localparam int MAX_FRAC_DIGITS = 9;

    // Token queue between classifier and parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_DOT   = 8'd46;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CH_HIGH  = 8'd128;

    typedef enum logic [2:0] {
        TOK_NUL,
        TOK_DIGIT,
        TOK_SPACE,
        TOK_MINUS,
        TOK_PLUS,
        TOK_DOT,
        TOK_OTHER
    } tok_class_t;

    typedef struct packed {
        tok_class_t           cls;
        logic [DIGIT_W-1:0]   digit;
    } token_t;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_INT,
        PH_FRAC,
        PH_DONE,
        PH_FAIL
    } phase_t;

    // Queue-side handshake seen by the parser
    typedef struct packed {
        logic   valid;
        token_t tok;
    } q_head_t;

    function automatic token_t classify(input logic [CH_W-1:0] c);
        token_t t;
        logic [CH_W-1:0] diff;
        diff    = c - CH_ZERO;
        t.digit = diff[DIGIT_W-1:0];
        if (c == CH_NUL) begin
            t.cls = TOK_NUL;
        end
        else if (c >= CH_HIGH) begin
            t.cls = TOK_OTHER;
        end
        else if (c >= CH_ZERO && c <= CH_NINE) begin
            t.cls = TOK_DIGIT;
        end
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            t.cls = TOK_SPACE;
        end
        else if (c == CH_MINUS) begin
            t.cls = TOK_MINUS;
        end
        else if (c == CH_PLUS) begin
            t.cls = TOK_PLUS;
        end
        else if (c == CH_DOT) begin
            t.cls = TOK_DOT;
        end
        else begin
            t.cls = TOK_OTHER;
        end
        return t;
    endfunction

endpackage

[rtl/adnp_front.sv]
`timescale 1ns / 1ps

module adnp_front (
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [adnp_pkg::CH_W-1:0] ch,
    input  logic                      q_full,
    output logic                      push,
    output adnp_pkg::token_t          push_tok
);
    import adnp_pkg::*;

    // Stall only on a full queue; never on the output side
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign push_tok = classify(ch);

endmodule

[rtl/adnp_queue.sv]
`timescale 1ns / 1ps

module adnp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  adnp_pkg::token_t    push_tok,
    output logic                full,
    output adnp_pkg::q_head_t   head,
    input  logic                pop
);
    import adnp_pkg::*;

    token_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.tok   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[rtl/adnp_back.sv]
`timescale 1ns / 1ps

module adnp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  adnp_pkg::q_head_t                 head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              valid_res,
    output logic                              negative,
    output logic [adnp_pkg::INT_W-1:0]        magnitude,
    output logic signed [adnp_pkg::INT_W-1:0] signed_int,
    output logic [adnp_pkg::FRAC_W-1:0]       frac_value,
    output logic [adnp_pkg::FRAC_CNT_W-1:0]   frac_digits,
    output logic                              frac_overflow
);
    import adnp_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [INT_W-1:0]        int_reg, int_next;
    logic [FRAC_W-1:0]       frac_reg, frac_next;
    logic [FRAC_CNT_W-1:0]   fcnt_reg, fcnt_next;
    logic                    drop_reg, drop_next;
    logic                    ok_reg, ok_next;

    logic                    out_valid_reg;
    logic                    res_ok_reg;
    logic                    res_neg_reg;
    logic [INT_W-1:0]        res_mag_reg;
    logic [INT_W-1:0]        res_sint_reg;
    logic [FRAC_W-1:0]       res_frac_reg;
    logic [FRAC_CNT_W-1:0]   res_fcnt_reg;
    logic                    res_drop_reg;

    logic                    out_free;
    logic                    is_nul;
    logic                    is_digit;
    logic                    load_res;
    logic [INT_W-1:0]        int_mac;
    logic [FRAC_W-1:0]       frac_mac;
    logic                    frac_room;

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_nul    = (head.tok.cls == TOK_NUL);
    assign is_digit  = (head.tok.cls == TOK_DIGIT);
    // Hold a NUL in the queue until the result register can take it
    assign pop       = head.valid && (!is_nul || out_free);
    assign load_res  = pop && is_nul;

    // times ten as two shifts and an add
    assign int_mac   = (int_reg << 3) + (int_reg << 1) + INT_W'(head.tok.digit);
    assign frac_mac  = (frac_reg << 3) + (frac_reg << 1) + FRAC_W'(head.tok.digit);
    assign frac_room = (fcnt_reg < FRAC_CNT_W'(MAX_FRAC_DIGITS));

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pop) begin
            if (is_nul) begin
                phase_next = PH_SKIP;
            end
            else begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        unique case (head.tok.cls)
                            TOK_SPACE:           phase_next = PH_SKIP;
                            TOK_MINUS, TOK_PLUS: phase_next = PH_SIGNED;
                            TOK_DIGIT:           phase_next = PH_INT;
                            default:             phase_next = PH_FAIL;
                        endcase
                    end
                    PH_SIGNED: phase_next = is_digit ? PH_INT : PH_FAIL;
                    PH_INT:
                    begin
                        if (is_digit) begin
                            phase_next = PH_INT;
                        end
                        else if (head.tok.cls == TOK_DOT) begin
                            phase_next = PH_FRAC;
                        end
                        else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_FRAC:   phase_next = is_digit ? PH_FRAC : PH_DONE;
                    PH_DONE:   phase_next = PH_DONE;
                    PH_FAIL:   phase_next = PH_FAIL;
                    default:   phase_next = PH_FAIL;
                endcase
            end
        end
    end

    // Accumulator updates
    always_comb
    begin
        neg_next  = neg_reg;
        int_next  = int_reg;
        frac_next = frac_reg;
        fcnt_next = fcnt_reg;
        drop_next = drop_reg;
        ok_next   = ok_reg;
        if (pop) begin
            if (is_nul) begin
                neg_next  = 1'b0;
                int_next  = '0;
                frac_next = '0;
                fcnt_next = '0;
                drop_next = 1'b0;
                ok_next   = 1'b0;
            end
            else begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (head.tok.cls == TOK_MINUS || head.tok.cls == TOK_PLUS) begin
                            neg_next = (head.tok.cls == TOK_MINUS);
                        end
                        else if (is_digit) begin
                            int_next = INT_W'(head.tok.digit);
                            ok_next  = 1'b1;
                        end
                    end
                    PH_SIGNED:
                    begin
                        if (is_digit) begin
                            int_next = INT_W'(head.tok.digit);
                            ok_next  = 1'b1;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_digit) begin
                            int_next = int_mac;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (is_digit) begin
                            if (frac_room) begin
                                frac_next = frac_mac;
                                fcnt_next = fcnt_reg + FRAC_CNT_W'(1);
                            end
                            else begin
                                drop_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // done or failed: drop characters until NUL
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            fcnt_reg      <= '0;
            drop_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            drop_reg  <= drop_next;
            ok_reg    <= ok_next;
            if (load_res) begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register; no number gives all zeros
    always_ff @(posedge clk)
    begin
        if (load_res) begin
            res_ok_reg   <= ok_reg;
            res_neg_reg  <= ok_reg && neg_reg;
            res_mag_reg  <= ok_reg ? int_reg : '0;
            res_sint_reg <= !ok_reg ? '0 : (neg_reg ? (INT_W'(0) - int_reg) : int_reg);
            res_frac_reg <= ok_reg ? frac_reg : '0;
            res_fcnt_reg <= ok_reg ? fcnt_reg : '0;
            res_drop_reg <= ok_reg && drop_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign valid_res     = res_ok_reg;
    assign negative      = res_neg_reg;
    assign magnitude     = res_mag_reg;
    assign signed_int    = res_sint_reg;
    assign frac_value    = res_frac_reg;
    assign frac_digits   = res_fcnt_reg;
    assign frac_overflow = res_drop_reg;

    a_no_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ok_reg) |-> (res_mag_reg == '0 && res_sint_reg == '0 &&
            res_frac_reg == '0 && res_fcnt_reg == '0 && !res_neg_reg && !res_drop_reg))
        else $error("empty result carries nonzero fields");

    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FRAC_CNT_W'(MAX_FRAC_DIGITS))
        else $error("fraction digit count beyond limit");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> (fcnt_reg == FRAC_CNT_W'(MAX_FRAC_DIGITS) && phase_reg != PH_INT))
        else $error("digits dropped before fraction was full");

    a_ok_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !ok_reg |-> (phase_reg == PH_SKIP || phase_reg == PH_SIGNED || phase_reg == PH_FAIL))
        else $error("digit phase reached without a number");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !load_res)
        else $error("result overwritten while stalled");

endmodule

[rtl/ascii_decimal_number_parser_core.sv]
`timescale 1ns / 1ps

// ASCII decimal number parser. Feed one character per transaction on ch; a NUL
// ends the string and produces exactly one result transaction, while every
// other character produces none. Accepted form: leading whitespace (9..13, 32),
// an optional '+' or '-', one or more digits, then an optional '.' and fraction
// digits; parsing stops at the first character that does not fit and the rest
// up to the NUL is ignored. The value is (negative ? -1 : 1) *
// (magnitude + frac_value / 10^frac_digits); the integer part wraps mod 2^32,
// and fraction digits past nine are dropped and raise frac_overflow. A string
// with no digits after the optional sign gives valid_res = 0 and all other
// fields zero. Throughput is one character per clock: a classifier stalls
// only when the four-entry token queue is full, and the parser retires one
// token per cycle, except a NUL held by a stalled output, with a times-ten
// multiply-add as its longest path. An accepted character is written into
// the token queue and parsed once it reaches the head; popping a NUL
// loads its result into the output register. A stalled output holds back
// only the next NUL; characters keep entering the four-entry queue until full.

module ascii_decimal_number_parser_core (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [adnp_pkg::CH_W-1:0]         ch,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              valid_res,
    output logic                              negative,
    output logic [adnp_pkg::INT_W-1:0]        magnitude,
    output logic signed [adnp_pkg::INT_W-1:0] signed_int,
    output logic [adnp_pkg::FRAC_W-1:0]       frac_value,
    output logic [adnp_pkg::FRAC_CNT_W-1:0]   frac_digits,
    output logic                              frac_overflow
);
    import adnp_pkg::*;

    logic    push;
    token_t  push_tok;
    logic    q_full;
    q_head_t head;
    logic    pop;

    // Classify the incoming character into a token
    adnp_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .q_full   (q_full),
        .push     (push),
        .push_tok (push_tok)
    );

    // Decouple classification from parsing
    adnp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .full     (q_full),
        .head     (head),
        .pop      (pop)
    );

    // Run the grammar and hold the result until taken
    adnp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .valid_res     (valid_res),
        .negative      (negative),
        .magnitude     (magnitude),
        .signed_int    (signed_int),
        .frac_value    (frac_value),
        .frac_digits   (frac_digits),
        .frac_overflow (frac_overflow)
    );

endmodule
